/* design/hvst_pkg.sv */
// shared constants, codes and control structs for the hmm viterbi state tracker
package hvst_pkg;

   localparam int STATE_COUNT = 8;
   localparam int NUM_SYMBOLS = 16;
   localparam int STATE_W     = $clog2(STATE_COUNT);
   localparam int SYMBOL_W    = $clog2(NUM_SYMBOLS);
   localparam int LOGP_WIDTH  = 16;
   localparam int KIND_W      = 2;

   localparam logic signed [LOGP_WIDTH-1:0] LOGP_NEG_INF =
      {1'b1, {(LOGP_WIDTH-1){1'b0}}};

   typedef logic signed [LOGP_WIDTH-1:0] logp_type;
   typedef logic [STATE_W-1:0]           state_idx_type;
   typedef logic [SYMBOL_W-1:0]          symbol_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_TRANS = 2'd0,
      KIND_LOAD_EMIT  = 2'd1,
      KIND_OBSERVE    = 2'd2
   } kind_type;

   typedef struct packed {
      logic          write_tr;
      logic          write_em;
      logic          start;
      logic          issue;
      state_idx_type issue_idx;
      logic          normalize;
      logic          load_out;
   } hvst_cmd_type;

   typedef struct packed {
      logic out_free;
   } hvst_sts_type;

endpackage

/* design/hvst_req_if.sv */
// request channel carrying load and observe items
interface hvst_req_if;
   import hvst_pkg::*;

   logic          valid;
   logic          ready;
   logic [KIND_W-1:0] kind;
   state_idx_type from_state;
   state_idx_type to_state;
   symbol_type    observation;
   logp_type      log_prob;

   modport source (output valid, output kind, output from_state, output to_state,
                   output observation, output log_prob, input ready);
   modport sink   (input valid, input kind, input from_state, input to_state,
                   input observation, input log_prob, output ready);
endinterface

/* design/hvst_rsp_if.sv */
// response channel carrying the best current state
interface hvst_rsp_if;
   import hvst_pkg::*;

   logic          valid;
   logic          ready;
   state_idx_type best_state;

   modport source (output valid, output best_state, input ready);
   modport sink   (input valid, input best_state, output ready);
endinterface

/* design/hmm_viterbi_online_state_tracker_unit.sv */
// top level of the online hmm viterbi state tracker
//
// req_ch takes load and observe items. a transition or emission load is
// taken while idle and writes one table entry; kind 3 is taken and dropped.
// an observe item sweeps the eight target states, one per cycle, each target
// comparing all source states at once in the add-compare-select stage.
// after the sweep, the pipeline drains, the path metrics are renormalized,
// and the result register on rsp_ch is loaded.
// req_ch is closed from the time the observe item is taken until the result
// register is loaded, so a new observe is not taken before the last one is
// through the per-target sweep, drain and renormalization.
// a waiting result does not block loads; a further observe holds in its last
// step until the result register is taken.
// reset clears control state and sets the metrics to zero for state 0 and the
// floor for all others; table contents are undefined until written.
module hmm_viterbi_online_state_tracker_unit #(
   parameter int METRIC_WIDTH = 24
) (
   input logic       clock,
   input logic       reset,
   hvst_req_if.sink  req_ch,
   hvst_rsp_if.source rsp_ch
);
   import hvst_pkg::*;

   hvst_cmd_type cmd;
   hvst_sts_type sts;

   hvst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   hvst_datapath #(
      .METRIC_WIDTH (METRIC_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .from_state  (req_ch.from_state),
      .to_state    (req_ch.to_state),
      .observation (req_ch.observation),
      .log_prob    (req_ch.log_prob),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .best_state  (rsp_ch.best_state)
   );

endmodule

/* design/hvst_ctrl.sv */
// sequencer for loads, add-compare-select sweep and renormalization
module hvst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [hvst_pkg::KIND_W-1:0] req_kind,
   output logic                  req_ready,
   output hvst_pkg::hvst_cmd_type cmd,
   input  hvst_pkg::hvst_sts_type sts
);
   import hvst_pkg::*;

   localparam state_idx_type LAST_IDX  = STATE_W'(STATE_COUNT - 1);
   localparam state_idx_type LAST_DRAIN = STATE_W'(1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ISSUE  = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_NORM   = 5'b01000,
      ST_FINISH = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   state_idx_type  cnt_ff, cnt_in;
   logic           accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.issue_idx = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               case (req_kind)
                  KIND_LOAD_TRANS: cmd.write_tr = 1'b1;
                  KIND_LOAD_EMIT:  cmd.write_em = 1'b1;
                  KIND_OBSERVE: begin
                     cmd.start = 1'b1;
                     state_in  = ST_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + STATE_W'(1);
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == LAST_DRAIN) begin
               cnt_in   = '0;
               state_in = ST_NORM;
            end else begin
               cnt_in = cnt_ff + STATE_W'(1);
            end
         end
         ST_NORM: begin
            cmd.normalize = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* design/hvst_datapath.sv */
// tables, path metrics, add-compare-select pipeline and result register
module hvst_datapath #(
   parameter int METRIC_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hvst_pkg::hvst_cmd_type cmd,
   output hvst_pkg::hvst_sts_type sts,
   input  hvst_pkg::state_idx_type from_state,
   input  hvst_pkg::state_idx_type to_state,
   input  hvst_pkg::symbol_type   observation,
   input  hvst_pkg::logp_type     log_prob,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output hvst_pkg::state_idx_type best_state
);
   import hvst_pkg::*;

   localparam int MW = METRIC_WIDTH;
   localparam logic signed [MW-1:0] FLOOR = {1'b1, {(MW-1){1'b0}}};
   localparam logic signed [MW-1:0] CEIL  = {1'b0, {(MW-1){1'b1}}};

   typedef logic signed [MW-1:0] metric_type;
   typedef logic signed [MW:0]   wide_type;

   function automatic metric_type clamp(input wide_type v);
      metric_type r;
      if (v < wide_type'(FLOOR)) begin
         r = FLOOR;
      end else if (v > wide_type'(CEIL)) begin
         r = CEIL;
      end else begin
         r = v[MW-1:0];
      end
      return r;
   endfunction

   // transition rows are indexed by target state, lanes by source state
   logp_type tr_mem [STATE_COUNT][STATE_COUNT];
   logp_type em_mem [NUM_SYMBOLS*STATE_COUNT];

   logp_type      tr_row_ff [STATE_COUNT];
   logp_type      em_rd_ff;
   symbol_type    obs_ff;
   logic          rd_v_ff;
   state_idx_type rd_idx_ff;

   metric_type    acc_ff, acc_in;
   logp_type      em_ff;
   logic          acc_v_ff;
   state_idx_type acc_idx_ff;

   metric_type    pm_ff    [STATE_COUNT];
   metric_type    fresh_ff [STATE_COUNT];
   metric_type    fresh_in;
   metric_type    best_ff;
   state_idx_type best_idx_ff;

   logic          rsp_valid_ff;
   state_idx_type best_state_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_tr) begin
         tr_mem[to_state][from_state] <= log_prob;
      end
      if (cmd.issue) begin
         tr_row_ff <= tr_mem[cmd.issue_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_em) begin
         em_mem[{observation, to_state}] <= log_prob;
      end
      if (cmd.issue) begin
         em_rd_ff <= em_mem[{obs_ff, cmd.issue_idx}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         obs_ff <= observation;
      end
      rd_idx_ff  <= cmd.issue_idx;
      acc_ff     <= acc_in;
      acc_idx_ff <= rd_idx_ff;
      em_ff      <= em_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         acc_v_ff <= 1'b0;
      end else begin
         rd_v_ff  <= cmd.issue;
         acc_v_ff <= rd_v_ff;
      end
   end

   // best source candidate for one target
   always_comb begin
      metric_type cand;
      acc_in = FLOOR;
      for (int j = 0; j < STATE_COUNT; j++) begin
         if (tr_row_ff[j] == LOGP_NEG_INF || pm_ff[j] == FLOOR) begin
            cand = FLOOR;
         end else begin
            cand = clamp(wide_type'(pm_ff[j]) + wide_type'(tr_row_ff[j]));
         end
         if (j == 0 || cand > acc_in) begin
            acc_in = cand;
         end
      end
   end

   always_comb begin
      if (acc_ff == FLOOR || em_ff == LOGP_NEG_INF) begin
         fresh_in = FLOOR;
      end else begin
         fresh_in = clamp(wide_type'(acc_ff) + wide_type'(em_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (acc_v_ff) begin
         fresh_ff[acc_idx_ff] <= fresh_in;
         if (acc_idx_ff == '0 || fresh_in > best_ff) begin
            best_ff     <= fresh_in;
            best_idx_ff <= acc_idx_ff;
         end
      end
   end

   // renormalize so the best metric is zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STATE_COUNT; i++) begin
            pm_ff[i] <= (i == 0) ? metric_type'(0) : FLOOR;
         end
      end else if (cmd.normalize) begin
         for (int i = 0; i < STATE_COUNT; i++) begin
            if (fresh_ff[i] == FLOOR || best_ff == FLOOR) begin
               pm_ff[i] <= FLOOR;
            end else begin
               pm_ff[i] <= clamp(wide_type'(fresh_ff[i]) - wide_type'(best_ff));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         best_state_ff <= best_idx_ff;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign best_state   = best_state_ff;

endmodule

/* design/hvst_checker.sv */
// port-level checks for the state tracker, bound to the top level
module hvst_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [hvst_pkg::KIND_W-1:0] req_kind,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input hvst_pkg::state_idx_type best_state
);
   import hvst_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(best_state))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_observe_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_OBSERVE |=> !req_ready)
      else $error("request channel open right after an observe item");

   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a busy cycle");

endmodule

bind hmm_viterbi_online_state_tracker_unit hvst_checker u_hvst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_kind   (req_ch.kind),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .best_state (rsp_ch.best_state)
);
